// ===== design/assert_macros.svh =====
// Assertion macros used by the extended GCD unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define EGCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define EGCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/egcd_pkg.sv =====
// ----------------------------------------------------------------------------
// egcd_pkg
// Widths, sequencer states and control structs of the extended GCD unit.
// ----------------------------------------------------------------------------
package egcd_pkg;

  localparam int WIDTH  = 32;
  localparam int COEF_W = WIDTH + 1;
  localparam int CNT_W  = $clog2(WIDTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FIN
  } egcd_state_t;

  typedef struct packed {
    logic start;
  } egcd_div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } egcd_div_sts_t;

endpackage

// ===== design/egcd_if.sv =====
// ----------------------------------------------------------------------------
// egcd_in_if / egcd_out_if
// Valid/ready channels carrying the operand pair and the result triple.
// ----------------------------------------------------------------------------
interface egcd_in_if import egcd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] first_value;
  logic [WIDTH-1:0] second_value;

  modport source (output valid, output first_value, output second_value, input ready);
  modport sink   (input valid, input first_value, input second_value, output ready);
endinterface

interface egcd_out_if import egcd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [WIDTH-1:0]         divisor;
  logic signed [COEF_W-1:0] coef_first;
  logic signed [COEF_W-1:0] coef_second;

  modport source (output valid, output divisor, output coef_first, output coef_second,
                  input ready);
  modport sink   (input valid, input divisor, input coef_first, input coef_second,
                  output ready);
endinterface

// ===== design/egcd_divider.sv =====
// ----------------------------------------------------------------------------
// egcd_divider
// Restoring divider, one quotient bit per cycle, with the quotient folded
// into two multiply accumulators (q*s and q*t) as its bits come out.
// ----------------------------------------------------------------------------
module egcd_divider import egcd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  egcd_div_ctl_t       ctl,
  output egcd_div_sts_t       sts,
  input  logic [WIDTH-1:0]    dividend,
  input  logic [WIDTH-1:0]    divisor,   // held stable by the caller while busy
  input  logic [COEF_W-1:0]   mul_s,     // held stable by the caller while busy
  input  logic [COEF_W-1:0]   mul_t,     // held stable by the caller while busy
  output logic [WIDTH-1:0]    remainder,
  output logic [COEF_W-1:0]   prod_s,
  output logic [COEF_W-1:0]   prod_t
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WIDTH-1:0]  dvd_r, dvd_nxt;
  logic [WIDTH-1:0]  rem_r, rem_nxt;
  logic [COEF_W-1:0] qs_r, qs_nxt;
  logic [COEF_W-1:0] qt_r, qt_nxt;

  logic [WIDTH:0]    trial;
  logic [WIDTH:0]    diff;
  logic              take;

  always_comb begin
    trial = {rem_r, dvd_r[WIDTH-1]};
    diff  = trial - {1'b0, divisor};
    take  = (trial >= {1'b0, divisor});

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    qs_nxt   = qs_r;
    qt_nxt   = qt_r;

    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      qs_nxt   = '0;
      qt_nxt   = '0;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract when it fits
      dvd_nxt = {dvd_r[WIDTH-2:0], 1'b0};
      rem_nxt = take ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      qs_nxt  = {qs_r[COEF_W-2:0], 1'b0} + (take ? mul_s : '0);
      qt_nxt  = {qt_r[COEF_W-2:0], 1'b0} + (take ? mul_t : '0);
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(WIDTH - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    qs_r  <= qs_nxt;
    qt_r  <= qt_nxt;
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign remainder = rem_r;
  assign prod_s    = qs_r;
  assign prod_t    = qt_r;

endmodule

// ===== design/extended_gcd_bezout_unit.sv =====
// ----------------------------------------------------------------------------
// extended_gcd_bezout_unit
// Greatest common divisor of two unsigned operands with Bezout coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries a request (first_value a, second_value b). out_ch returns
//   divisor g and signed coefficients coef_first s, coef_second t with
//   s*a + t*b = g. One result per request, in order.
//   Each Euclid step runs the shared divider, one quotient bit per cycle
//   after its start, then updates the remainder and coefficient pairs.
//   A request takes k Euclid steps; k is at most 46 for 32-bit operands.
//   in_ch.ready is high only while the sequencer is idle; one request is in
//   work at a time.
//   The result sits in an output register: the next request is accepted while
//   it waits, and a stalled receiver holds the finished item in the sequencer
//   until the register frees up.
//   Synchronous reset (rst_n low) drops any request in work and clears
//   out_ch.valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module extended_gcd_bezout_unit import egcd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  egcd_in_if.sink    in_ch,
  egcd_out_if.source out_ch
);

  egcd_state_t       state_r, state_nxt;
  logic [WIDTH-1:0]  r0_r, r0_nxt, r1_r, r1_nxt;
  logic [COEF_W-1:0] s0_r, s0_nxt, s1_r, s1_nxt;
  logic [COEF_W-1:0] t0_r, t0_nxt, t1_r, t1_nxt;
  logic              zero_r, zero_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0]  out_div_r, out_div_nxt;
  logic [COEF_W-1:0] out_s_r, out_s_nxt;
  logic [COEF_W-1:0] out_t_r, out_t_nxt;

  egcd_div_ctl_t     div_ctl;
  egcd_div_sts_t     div_sts;
  logic [WIDTH-1:0]  div_rem;
  logic [COEF_W-1:0] div_qs;
  logic [COEF_W-1:0] div_qt;

  egcd_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .sts       (div_sts),
    .dividend  (r0_r),
    .divisor   (r1_r),
    .mul_s     (s1_r),
    .mul_t     (t1_r),
    .remainder (div_rem),
    .prod_s    (div_qs),
    .prod_t    (div_qt)
  );

  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    r0_nxt        = r0_r;
    r1_nxt        = r1_r;
    s0_nxt        = s0_r;
    s1_nxt        = s1_r;
    t0_nxt        = t0_r;
    t1_nxt        = t1_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r;
    out_div_nxt   = out_div_r;
    out_s_nxt     = out_s_r;
    out_t_nxt     = out_t_r;
    div_ctl.start = 1'b0;

    // drop the result once the receiver takes it
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          r0_nxt    = in_ch.first_value;
          r1_nxt    = in_ch.second_value;
          s0_nxt    = COEF_W'(1);
          s1_nxt    = '0;
          t0_nxt    = '0;
          t1_nxt    = COEF_W'(1);
          zero_nxt  = (in_ch.first_value == '0) && (in_ch.second_value == '0);
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (r1_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          div_ctl.start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        // advance the remainder and coefficient pairs once the quotient products are ready
        if (div_sts.done) begin
          r0_nxt    = r1_r;
          r1_nxt    = div_rem;
          s0_nxt    = s1_r;
          s1_nxt    = s0_r - div_qs;
          t0_nxt    = t1_r;
          t1_nxt    = t0_r - div_qt;
          state_nxt = ST_CHECK;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_div_nxt   = r0_r;
          out_s_nxt     = zero_r ? '0 : s0_r;
          out_t_nxt     = t0_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r0_r      <= r0_nxt;
    r1_r      <= r1_nxt;
    s0_r      <= s0_nxt;
    s1_r      <= s1_nxt;
    t0_r      <= t0_nxt;
    t1_r      <= t1_nxt;
    zero_r    <= zero_nxt;
    out_div_r <= out_div_nxt;
    out_s_r   <= out_s_nxt;
    out_t_r   <= out_t_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.divisor     = out_div_r;
  assign out_ch.coef_first  = out_s_r;
  assign out_ch.coef_second = out_t_r;

  `EGCD_ASSERT(a_busy_after_accept, (in_ch.valid && in_ch.ready) |=> !in_ch.ready, "request accepted but block still ready")
  `EGCD_ASSERT(a_start_when_free, div_ctl.start |-> !div_sts.busy, "divider started while busy")
  `EGCD_ASSERT(a_div_only_in_div, div_sts.busy |-> (state_r == ST_DIV), "divider running outside the division state")
  `EGCD_ASSERT(a_zero_gcd_coefs, (out_ch.valid && (out_ch.divisor == '0)) |-> ((out_ch.coef_first == '0) && (out_ch.coef_second == '0)), "zero gcd with nonzero coefficients")
  `EGCD_ASSERT_ALWAYS(a_hold_stalled, (rst_n && out_ch.valid && !out_ch.ready) |=> (!rst_n || out_ch.valid), "stalled result dropped")

endmodule

// ===== tb/bezout_checker.sv =====
// ----------------------------------------------------------------------------
// bezout_checker
// Watches the request and result channels of the extended GCD unit, predicts
// gcd and Bezout coefficients for every accepted request, and compares them
// field by field against the results in arrival order.
// ----------------------------------------------------------------------------
module bezout_checker import egcd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  egcd_in_if   in_ch,
  egcd_out_if  out_ch,
  output int   err_count,
  output int   pending_cnt
);

  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [WIDTH-1:0]         first_value;
    logic [WIDTH-1:0]         second_value;
    logic [WIDTH-1:0]         divisor;
    logic signed [COEF_W-1:0] coef_first;
    logic signed [COEF_W-1:0] coef_second;
  } bezout_t;

  bezout_t expected_bezout_q[$];

  // Iterative extended Euclid; coefficients wrap modulo 2^64, low bits exact.
  function automatic bezout_t bezout_of(logic [WIDTH-1:0] a, logic [WIDTH-1:0] b);
    bit [63:0] r0, r1, s0, s1, t0, t1, q, nr, ns, nt;
    bezout_t   res;
    res.first_value  = a;
    res.second_value = b;
    r0 = 64'(a);
    r1 = 64'(b);
    s0 = 64'd1;
    s1 = 64'd0;
    t0 = 64'd0;
    t1 = 64'd1;
    if (r0 == 0 && r1 == 0) begin
      res.divisor     = '0;
      res.coef_first  = '0;
      res.coef_second = '0;
      return res;
    end
    while (r1 != 0) begin
      q  = r0 / r1;
      nr = r0 - q * r1;
      ns = s0 - q * s1;
      nt = t0 - q * t1;
      r0 = r1;
      r1 = nr;
      s0 = s1;
      s1 = ns;
      t0 = t1;
      t1 = nt;
    end
    res.divisor     = r0[WIDTH-1:0];
    res.coef_first  = s0[COEF_W-1:0];
    res.coef_second = t0[COEF_W-1:0];
    return res;
  endfunction

  initial begin
    err_count   = 0;
    pending_cnt = 0;
  end

  always @(posedge clk) begin
    bezout_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        expected_bezout_q.push_back(bezout_of(in_ch.first_value, in_ch.second_value));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bezout_q.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("unexpected result: divisor=%0d s=%0d t=%0d",
                     out_ch.divisor, out_ch.coef_first, out_ch.coef_second);
        end else begin
          want = expected_bezout_q.pop_front();
          if (out_ch.divisor !== want.divisor || out_ch.coef_first !== want.coef_first ||
              out_ch.coef_second !== want.coef_second) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("mismatch a=%0d b=%0d: exp g=%0d s=%0d t=%0d, got g=%0d s=%0d t=%0d",
                       want.first_value, want.second_value,
                       want.divisor, want.coef_first, want.coef_second,
                       out_ch.divisor, out_ch.coef_first, out_ch.coef_second);
          end
        end
      end
    end
    pending_cnt = expected_bezout_q.size();
  end

endmodule

// ===== tb/extended_gcd_bezout_unit_tb.sv =====
// ----------------------------------------------------------------------------
// extended_gcd_bezout_unit_tb
// Drives operand pairs into the extended GCD unit: corner cases first, then
// random pairs of several shapes under four sender/receiver idling phases.
// The checker beside the unit predicts and compares; this top decides.
// ----------------------------------------------------------------------------
module extended_gcd_bezout_unit_tb;
  import egcd_pkg::*;

  localparam int QUIET_LIMIT     = 20000;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int DRAIN_CYCLES    = 40;

  logic clk;
  logic rst_n;
  int   idle_pct;
  int   stall_pct;
  int   quiet_cycles;
  int   err_count;
  int   pending_cnt;

  egcd_in_if  in_ch ();
  egcd_out_if out_ch ();

  extended_gcd_bezout_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bezout_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .err_count   (err_count),
    .pending_cnt (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Abort when no request and no result moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pair(input logic [WIDTH-1:0] a, input logic [WIDTH-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.first_value  <= a;
    in_ch.second_value <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_random_pair();
    logic [WIDTH-1:0] a, b, tmp;
    bit [63:0]        f0, f1, nxt, g;
    a = $urandom;
    b = $urandom;
    case ($urandom_range(9))
      4: begin
        a = $urandom_range(255);
        b = $urandom_range(255);
      end
      5: begin
        // shared factor
        g = $urandom_range(1, 65535);
        a = WIDTH'(g * $urandom_range(0, 32'(32'hFFFF_FFFF / g)));
        b = WIDTH'(g * $urandom_range(0, 32'(32'hFFFF_FFFF / g)));
      end
      6: b = '0;
      7: b = a;
      8: begin
        // consecutive Fibonacci numbers: longest step chains
        f0 = 64'd0;
        f1 = 64'd1;
        repeat ($urandom_range(1, 46)) begin
          nxt = f0 + f1;
          f0  = f1;
          f1  = nxt;
        end
        a = f1[WIDTH-1:0];
        b = f0[WIDTH-1:0];
      end
      9: a = '1 - WIDTH'($urandom_range(15));
      default: ;
    endcase
    if ($urandom_range(1)) begin
      tmp = a;
      a   = b;
      b   = tmp;
    end
    send_pair(a, b);
  endtask

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.first_value  = '0;
    in_ch.second_value = '0;
    out_ch.ready       = 1'b0;
    rst_n              = 1'b0;
    idle_pct           = 0;
    stall_pct          = 0;
    quiet_cycles       = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pair('0, '0);
    send_pair('0, 32'd12345);
    send_pair(32'd98765, '0);
    send_pair('0, '1);
    send_pair('1, '0);
    send_pair(32'd777, 32'd777);
    send_pair('1, '1);
    send_pair(32'd1, 32'd1);
    send_pair('1, 32'd1);
    send_pair(32'd1, '1);
    send_pair('1, '1 - 32'd1);
    send_pair(32'h8000_0000, 32'h4000_0000);
    send_pair(32'h8000_0000, '1);
    send_pair(32'hAAAA_AAAA, 32'h5555_5555);
    send_pair(32'd2971215073, 32'd1836311903);
    send_pair(32'd1836311903, 32'd2971215073);
    send_pair(32'd240, 32'd46);
    send_pair(32'd46, 32'd240);
    send_pair(32'd4294967291, 32'd4294967279);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 79; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 79; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      repeat (ITEMS_PER_PHASE) send_random_pair();
    end
    in_ch.valid <= 1'b0;

    // let the checker log the last request before looking at its count
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
